### design/lruwo_pkg.sv
// Package for the LRU way order tracker: sizes, command codes, the list type
// and the identity order function. No dependencies.
package lruwo_pkg;

    localparam int WAYS    = 4;
    localparam int SETS    = 64;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int SET_W   = $clog2(SETS);
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int FIELD_W = 2;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    typedef logic [WAYS-1:0][WAY_W-1:0] list_t;

    function automatic list_t identity_list();
        list_t l;
        for (int k = 0; k < WAYS; k++)
        begin
            l[k] = WAY_W'(k);
        end
        return l;
    endfunction

endpackage

### design/lruwo_req_if.sv
// Request channel of the LRU way order tracker: valid, ready and the request word.
// Depends on lruwo_pkg.
interface lruwo_req_if;
    import lruwo_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   set_index;
    logic [FIELD_W-1:0] way;

    modport source (output valid, cmd, set_index, way, input ready);
    modport sink (input valid, cmd, set_index, way, output ready);
endinterface

### design/lruwo_rsp_if.sv
// Response channel of the LRU way order tracker: valid, ready and the result word.
// Depends on lruwo_pkg.
interface lruwo_rsp_if;
    import lruwo_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] victim_way;
    logic [FIELD_W-1:0] newest_way;

    modport source (output valid, victim_way, newest_way, input ready);
    modport sink (input valid, victim_way, newest_way, output ready);
endinterface

### design/lruwo_update.sv
// Recency list update: query, move-to-front touch and set order reset.
// Depends on lruwo_pkg.
module lruwo_update
    import lruwo_pkg::*;
(
    input  logic [CMD_W-1:0]   cmd,
    input  logic [FIELD_W-1:0] way,
    input  list_t              list_in,
    output list_t              list_out
);

    always_comb
    begin
        logic [WAY_W-1:0] w;
        logic [WAY_W-1:0] pos;
        logic             found;
        w        = WAY_W'(way);
        pos      = WAY_W'(WAYS - 1);
        found    = 1'b0;
        list_out = list_in;
        for (int k = 0; k < WAYS; k++)
        begin
            if (!found && list_in[k] == w)
            begin
                pos   = WAY_W'(k);
                found = 1'b1;
            end
        end
        case (cmd)
            CMD_TOUCH:
            begin
                if (32'(way) < WAYS)
                begin
                    for (int k = WAYS - 1; k > 0; k--)
                    begin
                        if (WAY_W'(k) <= pos)
                        begin
                            list_out[k] = list_in[k-1];
                        end
                    end
                    list_out[0] = w;
                end
            end
            CMD_RESET:
            begin
                list_out = identity_list();
            end
            default:
            begin
                list_out = list_in;
            end
        endcase
    end

endmodule

### design/lru_way_order_tracker.sv
// Top level of the LRU way order tracker: recency list memory, update stage and
// result register. Depends on lruwo_pkg, lruwo_req_if, lruwo_rsp_if and lruwo_update.
//
// The tracker takes one request word per cycle unless a stalled result side holds
// the update stage, and returns one result word for each, in order, via the update
// stage and result register. The recency lists live in a memory with a registered
// read: the accept cycle reads the set's list; the update stage updates it, writes
// it back and loads the result register. A request to the set being written in the
// same cycle takes the new list through a forwarding path. Per-set valid bits make
// every set read as the order 0,1,2,3 after reset, so no clearing pass is needed.
module lru_way_order_tracker
    import lruwo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lruwo_req_if.sink   req,
    lruwo_rsp_if.source rsp
);

    list_t              mem [SETS];
    logic [SETS-1:0]    set_valid_reg;

    logic               s1_valid_reg;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic [SET_W-1:0]   s1_set_reg;
    logic [FIELD_W-1:0] s1_way_reg;
    list_t              rd_data_reg;
    logic               valid_rd_reg;
    logic               fwd_hit_reg;
    list_t              fwd_data_reg;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] victim_reg;
    logic [FIELD_W-1:0] newest_reg;

    logic               accept;
    logic               s1_fire;
    logic [SET_W-1:0]   acc_set;
    list_t              cur_list;
    list_t              new_list;

    assign acc_set  = req.set_index[SET_W-1:0];
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign accept   = req.valid && req.ready;

    assign cur_list = fwd_hit_reg  ? fwd_data_reg :
                      valid_rd_reg ? rd_data_reg  : identity_list();

    lruwo_update u_update (
        .cmd      (s1_cmd_reg),
        .way      (s1_way_reg),
        .list_in  (cur_list),
        .list_out (new_list)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= mem[acc_set];
            valid_rd_reg <= set_valid_reg[acc_set];
            fwd_hit_reg  <= s1_fire && (s1_set_reg == acc_set);
            fwd_data_reg <= new_list;
            s1_cmd_reg   <= req.cmd;
            s1_set_reg   <= acc_set;
            s1_way_reg   <= req.way;
        end
        if (s1_fire)
        begin
            mem[s1_set_reg] <= new_list;
            victim_reg      <= FIELD_W'(new_list[WAYS-1]);
            newest_reg      <= FIELD_W'(new_list[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                set_valid_reg[s1_set_reg] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.victim_way = victim_reg;
    assign rsp.newest_way = newest_reg;

    // An accepted request always occupies the update stage in the next cycle.
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request did not reach the update stage");

    // A completed update always presents a result in the next cycle.
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> rsp.valid)
        else $error("update completed without a result");

    // A touch of an existing way makes that way the newest one.
    a_touch_newest: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == CMD_TOUCH) |=> rsp.newest_way == $past(s1_way_reg))
        else $error("touched way is not the newest way");

    // A set order reset reports the identity order's ends.
    a_reset_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == CMD_RESET) |=>
            (rsp.newest_way == '0 && rsp.victim_way == FIELD_W'(WAYS - 1)))
        else $error("set order reset gave a wrong result");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for lru_way_order_tracker: a directed table followed by random request words,
// with each result word checked against a fixed table result or a recency list
// predictor. Depends on lruwo_pkg, lruwo_req_if, lruwo_rsp_if and the tracker RTL.
module tb_top;
    import lruwo_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10;
    localparam int DIR_ROWS = 23;
    localparam int PHASE_ITEMS = 182;

    typedef struct packed {
        logic [FIELD_W-1:0] victim;
        logic [FIELD_W-1:0] newest;
    } way_pair_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   set_index;
        logic [FIELD_W-1:0] way;
        bit                 fixed;
        way_pair_t          result;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lruwo_req_if req();
    lruwo_rsp_if rsp();

    lru_way_order_tracker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [WAY_W-1:0] lru_order [SETS][WAYS];
    way_pair_t        pending_results [$];
    dir_row_t         dir_rows [DIR_ROWS];
    int               errors;
    int               quiet_cycles;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    logic [IDX_W-1:0] hot_set;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic way_pair_t track_lru(input logic [CMD_W-1:0] c,
                                            input logic [IDX_W-1:0] s,
                                            input logic [FIELD_W-1:0] w);
        int        set_no;
        int        pos;
        way_pair_t r;
        set_no = int'(s) % SETS;
        if (c == CMD_TOUCH && int'(w) < WAYS)
        begin
            pos = WAYS - 1;
            for (int k = WAYS - 1; k >= 0; k--)
            begin
                if (lru_order[set_no][k] == w)
                begin
                    pos = k;
                end
            end
            for (int k = pos; k > 0; k--)
            begin
                lru_order[set_no][k] = lru_order[set_no][k - 1];
            end
            lru_order[set_no][0] = WAY_W'(w);
        end
        else if (c == CMD_RESET)
        begin
            for (int k = 0; k < WAYS; k++)
            begin
                lru_order[set_no][k] = WAY_W'(k);
            end
        end
        r.victim = FIELD_W'(lru_order[set_no][WAYS - 1]);
        r.newest = FIELD_W'(lru_order[set_no][0]);
        return r;
    endfunction

    task automatic issue_word(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] s,
                              input logic [FIELD_W-1:0] w, input bit fixed,
                              input way_pair_t fixed_result);
        way_pair_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req.valid = 1'b0;
            req.cmd = CMD_W'($urandom);
            req.set_index = IDX_W'($urandom);
            req.way = FIELD_W'($urandom);
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.cmd = c;
        req.set_index = s;
        req.way = w;
        do
        begin
            @(posedge clk);
        end
        while (req.ready !== 1'b1);
        predicted = track_lru(c, s, w);
        pending_results.push_back(fixed ? fixed_result : predicted);
    endtask

    task automatic drain_pause();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        logic [CMD_W-1:0]   c;
        logic [IDX_W-1:0]   s;
        int                 pick;
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                drain_pause();
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                c = CMD_TOUCH;
            end
            else if (pick < 85)
            begin
                c = CMD_QUERY;
            end
            else if (pick < 93)
            begin
                c = CMD_RESET;
            end
            else
            begin
                c = CMD_SPARE;
            end
            if ($urandom_range(9) == 0)
            begin
                hot_set = IDX_W'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                s = hot_set;
            end
            else if (pick < 75)
            begin
                s = ($urandom_range(1) == 0) ? IDX_W'(0) : IDX_W'(SETS - 1);
            end
            else
            begin
                s = IDX_W'($urandom);
            end
            issue_word(c, s, FIELD_W'($urandom), 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        rsp.ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                 (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        way_pair_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, victim_way %0d newest_way %0d",
                         $time, rsp.victim_way, rsp.newest_way);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.victim_way !== want.victim)
                begin
                    $display("%0t: victim_way expected %0d, got %0d",
                             $time, want.victim, rsp.victim_way);
                    errors++;
                end
                if (rsp.newest_way !== want.newest)
                begin
                    $display("%0t: newest_way expected %0d, got %0d",
                             $time, want.newest, rsp.newest_way);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_QUERY;
        req.set_index = '0;
        req.way = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hot_set = '0;
        for (int s = 0; s < SETS; s++)
        begin
            for (int k = 0; k < WAYS; k++)
            begin
                lru_order[s][k] = WAY_W'(k);
            end
        end
        dir_rows = '{
            '{CMD_QUERY, 6'd0,  2'd0, 1'b1, '{2'd3, 2'd0}},
            '{CMD_QUERY, 6'd63, 2'd3, 1'b1, '{2'd3, 2'd0}},
            '{CMD_TOUCH, 6'd63, 2'd3, 1'b1, '{2'd2, 2'd3}},
            '{CMD_TOUCH, 6'd63, 2'd2, 1'b1, '{2'd1, 2'd2}},
            '{CMD_TOUCH, 6'd63, 2'd2, 1'b1, '{2'd1, 2'd2}},
            '{CMD_SPARE, 6'd63, 2'd1, 1'b1, '{2'd1, 2'd2}},
            '{CMD_RESET, 6'd63, 2'd3, 1'b1, '{2'd3, 2'd0}},
            '{CMD_TOUCH, 6'd0,  2'd0, 1'b1, '{2'd3, 2'd0}},
            '{CMD_TOUCH, 6'd0,  2'd3, 1'b1, '{2'd2, 2'd3}},
            '{CMD_TOUCH, 6'd0,  2'd1, 1'b1, '{2'd2, 2'd1}},
            '{CMD_TOUCH, 6'd0,  2'd2, 1'b1, '{2'd0, 2'd2}},
            '{CMD_TOUCH, 6'd0,  2'd0, 1'b1, '{2'd3, 2'd0}},
            '{CMD_QUERY, 6'd0,  2'd2, 1'b1, '{2'd3, 2'd0}},
            '{CMD_RESET, 6'd0,  2'd1, 1'b1, '{2'd3, 2'd0}},
            '{CMD_TOUCH, 6'd42, 2'd1, 1'b0, '{2'd0, 2'd0}},
            '{CMD_TOUCH, 6'd42, 2'd2, 1'b0, '{2'd0, 2'd0}},
            '{CMD_TOUCH, 6'd21, 2'd3, 1'b0, '{2'd0, 2'd0}},
            '{CMD_TOUCH, 6'd42, 2'd0, 1'b0, '{2'd0, 2'd0}},
            '{CMD_SPARE, 6'd21, 2'd0, 1'b0, '{2'd0, 2'd0}},
            '{CMD_QUERY, 6'd42, 2'd3, 1'b0, '{2'd0, 2'd0}},
            '{CMD_TOUCH, 6'd21, 2'd1, 1'b0, '{2'd0, 2'd0}},
            '{CMD_RESET, 6'd21, 2'd0, 1'b0, '{2'd0, 2'd0}},
            '{CMD_TOUCH, 6'd42, 2'd3, 1'b0, '{2'd0, 2'd0}}
        };
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Back-to-back words to the same set exercise the forwarding path.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            issue_word(dir_rows[i].cmd, dir_rows[i].set_index, dir_rows[i].way,
                       dir_rows[i].fixed, dir_rows[i].result);
        end
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(83, 0, PHASE_ITEMS);
        run_phase(0, 83, PHASE_ITEMS);
        run_phase(38, 38, PHASE_ITEMS);

        @(negedge clk);
        req.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
